@@ rtl/gic_pkg.sv @@
// Package with the word types and fixed constants of the grid island counter.
package gic_pkg;

  localparam int CFG_W   = 7;
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic cell_is_land;
    logic last_cell;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] island_count;
    logic               overflow;
  } out_word_t;

endpackage

@@ rtl/gic_front.sv @@
// Front part: accepts input words into a short queue toward the walk engine.
module gic_front import gic_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     q_valid,
  output in_word_t q_word,
  input  logic     q_pop
);

  in_word_t    buf_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  fill_r;
  logic        push;
  logic        pop;

  assign in_stall = (fill_r == 3'd4);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 3'd0);
  assign pop      = q_pop && q_valid;
  assign q_word   = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 3'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 3'd1;
      end
    end
  end

endmodule

@@ rtl/gic_back.sv @@
// Back part: stores the grid, walks the land regions and holds the result word.
module gic_back import gic_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  in_word_t         q_word,
  output logic             q_pop,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  localparam int CAP  = MAX_ROWS * MAX_COLS;
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int NW   = $clog2(CAP + 1);
  localparam int SW   = NW + 1;
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int COLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef struct packed {
    logic [AW-1:0]   node;
    logic [COLW-1:0] col;
  } wq_entry_t;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_SCHK, S_POP, S_NODE, S_NRD, S_NCHK, S_DONE
  } state_t;

  state_t           state_r;
  logic [CFG_W-1:0] cfg_r;
  logic [CW-1:0]    cols;
  logic [NW-1:0]    cnt_r;
  logic             ovf_r;
  logic [NW-1:0]    start_r;
  logic [COLW-1:0]  start_col_r;
  logic [NW-1:0]    head_r;
  logic [NW-1:0]    tail_r;
  logic [AW-1:0]    node_r;
  logic [COLW-1:0]  col_r;
  logic [1:0]       nb_r;
  logic [AW-1:0]    nb_addr_r;
  logic [COLW-1:0]  nb_col_r;
  logic [COUNT_W-1:0] count_r;
  out_word_t        out_r;
  logic             out_valid_r;

  logic [1:0]       cell_mem [CAP];
  logic [1:0]       cell_rd_r;
  wq_entry_t        wq_mem [CAP];
  wq_entry_t        wq_rd_r;

  logic [SW-1:0]    node_x;
  logic [SW-1:0]    cols_x;
  logic [SW-1:0]    nb_addr;
  logic [COLW-1:0]  nb_col;
  logic             nb_ok;
  logic             cell_we;
  logic [AW-1:0]    cell_wa;
  logic [1:0]       cell_wd;
  logic             cell_re;
  logic [AW-1:0]    cell_ra;
  logic             wq_we;
  logic [NW-1:0]    start_nxt;
  logic             open_land;

  always_comb begin
    if (cfg_r == '0) begin
      cols = CW'(1);
    end else if (32'(cfg_r) > 32'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(cfg_r);
    end
  end

  assign node_x    = SW'(node_r);
  assign cols_x    = SW'(cols);
  assign open_land = cell_rd_r[1] && !cell_rd_r[0];
  assign start_nxt = start_r + NW'(1);

  always_comb begin
    nb_addr = node_x;
    nb_col  = col_r;
    nb_ok   = 1'b0;
    unique case (nb_r)
      2'd0: begin
        nb_addr = node_x - cols_x;
        nb_ok   = node_x >= cols_x;
      end
      2'd1: begin
        nb_addr = node_x + cols_x;
        nb_ok   = 1'b1;
      end
      2'd2: begin
        nb_addr = node_x - SW'(1);
        nb_col  = col_r - COLW'(1);
        nb_ok   = col_r != '0;
      end
      default: begin
        nb_addr = node_x + SW'(1);
        nb_col  = col_r + COLW'(1);
        nb_ok   = (CW'(col_r) + CW'(1)) < cols;
      end
    endcase
    nb_ok = nb_ok && (nb_addr < SW'(cnt_r));
  end

  assign q_pop = (state_r == S_LOAD);

  always_comb begin
    cell_we = 1'b0;
    cell_wa = cnt_r[AW-1:0];
    cell_wd = {q_word.cell_is_land, 1'b0};
    unique case (state_r)
      S_LOAD: cell_we = q_valid && (cnt_r < NW'(CAP));
      S_SCHK: begin
        cell_we = open_land;
        cell_wa = start_r[AW-1:0];
        cell_wd = 2'b11;
      end
      S_NCHK: begin
        cell_we = open_land;
        cell_wa = nb_addr_r;
        cell_wd = 2'b11;
      end
      default: cell_we = 1'b0;
    endcase
  end

  assign cell_re = (state_r == S_SCAN) || (state_r == S_NRD && nb_ok);
  assign cell_ra = (state_r == S_SCAN) ? start_r[AW-1:0] : nb_addr[AW-1:0];
  assign wq_we   = ((state_r == S_SCHK) || (state_r == S_NCHK)) && open_land;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (wq_we) begin
      if (state_r == S_SCHK) begin
        wq_mem[AW'(0)] <= '{node: start_r[AW-1:0], col: start_col_r};
      end else begin
        wq_mem[tail_r[AW-1:0]] <= '{node: nb_addr_r, col: nb_col_r};
      end
    end
    if (state_r == S_POP) begin
      wq_rd_r <= wq_mem[head_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cfg_r       <= CFG_W'(64);
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      start_r     <= '0;
      start_col_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      nb_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (q_valid) begin
            if (cnt_r < NW'(CAP)) begin
              cnt_r <= cnt_r + NW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (q_word.last_cell) begin
              start_r     <= '0;
              start_col_r <= '0;
              count_r     <= '0;
              if (cnt_r == '0 && 32'(CAP) > 0) begin
                state_r <= S_SCAN;
              end else begin
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (open_land) begin
            head_r <= '0;
            tail_r <= NW'(1);
            if (count_r != COUNT_MAX) begin
              count_r <= count_r + COUNT_W'(1);
            end
            state_r <= S_POP;
          end else begin
            start_r <= start_nxt;
            if (CW'(start_col_r) + CW'(1) == cols) begin
              start_col_r <= '0;
            end else begin
              start_col_r <= start_col_r + COLW'(1);
            end
            state_r <= (start_nxt >= cnt_r) ? S_DONE : S_SCAN;
          end
        end
        S_POP: begin
          if (head_r == tail_r) begin
            start_r <= start_nxt;
            if (CW'(start_col_r) + CW'(1) == cols) begin
              start_col_r <= '0;
            end else begin
              start_col_r <= start_col_r + COLW'(1);
            end
            state_r <= (start_nxt >= cnt_r) ? S_DONE : S_SCAN;
          end else begin
            head_r  <= head_r + NW'(1);
            state_r <= S_NODE;
          end
        end
        S_NODE: begin
          node_r  <= wq_rd_r.node;
          col_r   <= wq_rd_r.col;
          nb_r    <= '0;
          state_r <= S_NRD;
        end
        S_NRD: begin
          if (nb_ok) begin
            nb_addr_r <= nb_addr[AW-1:0];
            nb_col_r  <= nb_col;
            state_r   <= S_NCHK;
          end else begin
            nb_r    <= nb_r + 2'd1;
            state_r <= (nb_r == 2'd3) ? S_POP : S_NRD;
          end
        end
        S_NCHK: begin
          if (open_land) begin
            tail_r <= tail_r + NW'(1);
          end
          nb_r    <= nb_r + 2'd1;
          state_r <= (nb_r == 2'd3) ? S_POP : S_NRD;
        end
        default: begin
          if (!out_valid_r) begin
            out_r       <= '{island_count: count_r, overflow: ovf_r};
            out_valid_r <= 1'b1;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

@@ rtl/grid_island_counter_unit.sv @@
// Top level of the grid island counter: input queue, walk engine and config port.
//
//   port group   dir    handshake              word
//   in_          in     in_valid / in_stall    in_word  (cell_is_land, last_cell)
//   out_         out    out_valid / out_stall  out_word (island_count, overflow)
//   cfg_         in     cfg_valid / cfg_ready  cfg_data (columns_in_use)
//
// Cells are stored at one per cycle while loading, when the queue holds a word.
// After the final cell the walk scans each stored cell and each land cell's
// neighbours via the one cell memory read port. A four-word queue lets input
// flow on during a walk. Reset is synchronous, active low; no clearing pass
// is needed. A stalled result holds; the next grid still loads while it waits.
module grid_island_counter_unit import gic_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic     q_valid;
  logic     q_pop;
  in_word_t q_word;

  assign cfg_ready = 1'b1;

  gic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  gic_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ rtl/gic_checker.sv @@
// Port checker for the grid island counter, bound to the top level.
module gic_checker import gic_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input in_word_t         in_word,
  input logic             out_valid,
  input logic             out_stall,
  input out_word_t        out_word,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CFG_W-1:0] cfg_data
);

  localparam int BOUND = (MAX_ROWS * MAX_COLS + 1) / 2;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled result word changed.");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Result or stall present right after reset.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.island_count) <= BOUND ||
                   out_word.island_count == COUNT_MAX))
    else $error("Island count exceeds what the grid can hold.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("Configuration port refused a word.");

endmodule

bind grid_island_counter_unit gic_checker #(
  .MAX_ROWS (MAX_ROWS),
  .MAX_COLS (MAX_COLS)
) u_gic_checker (.*);
